// ----- sv/mck_pkg.sv -----
// package: shared types, microcode program and letter table for the morse keyer
`timescale 1ns / 1ps

package mck_pkg;

    localparam int UnitW = 16;
    localparam int DurW  = 18;
    localparam int CharW = 8;

    localparam logic [UnitW-1:0] UnitReset = 16'd100;

    localparam logic [CharW-1:0] ChSpace   = 8'h20;
    localparam logic [CharW-1:0] ChUpperA  = 8'h41;
    localparam logic [CharW-1:0] ChUpperZ  = 8'h5A;
    localparam logic [CharW-1:0] ChLowerA  = 8'h61;
    localparam logic [CharW-1:0] ChLowerZ  = 8'h7A;
    localparam logic [CharW-1:0] CaseShift = 8'h20;

    // microprogram addresses
    typedef enum logic [1:0] {
        STEP_FETCH = 2'd0,
        STEP_SYM   = 2'd1,
        STEP_GAP   = 2'd2,
        STEP_SPACE = 2'd3
    } t_step;

    // segment length selection
    typedef enum logic [1:0] {
        UNITS_MARK = 2'd0,  // 3 for a dash, 1 for a dot
        UNITS_GAP  = 2'd1,  // 3 after the final symbol, 1 otherwise
        UNITS_FOUR = 2'd2   // word space
    } t_units;

    // end-of-character flag selection
    typedef enum logic [1:0] {
        LAST_NO  = 2'd0,
        LAST_YES = 2'd1,
        LAST_SYM = 2'd2     // set on the final symbol of the letter
    } t_lastsel;

    // branch condition
    typedef enum logic [1:0] {
        COND_NEXT   = 2'd0, // go to next once the step completes
        COND_LAST   = 2'd1, // alt on final symbol, else next
        COND_DECODE = 2'd2  // dispatch on the accepted byte
    } t_cond;

    // one microcode word
    typedef struct packed {
        logic     accept;
        logic     emit;
        logic     tone;
        t_units   units;
        t_lastsel lastsel;
        logic     inc_sym;
        t_cond    cond;
        t_step    next;
        t_step    alt;
    } t_uword;

    // sequencer to datapath
    typedef struct packed {
        logic     load;
        logic     emit;
        logic     tone;
        t_units   units;
        t_lastsel lastsel;
        logic     inc_sym;
    } t_ctl;

    // datapath to sequencer
    typedef struct packed {
        logic out_free;
        logic sym_last;
        logic in_space;
        logic in_letter;
    } t_status;

    // control store
    function automatic t_uword ucode(input t_step step);
        t_uword w;
        w = '0;
        case (step)
            STEP_FETCH: begin
                w.accept = 1'b1;
                w.cond   = COND_DECODE;
                w.next   = STEP_SYM;
                w.alt    = STEP_SPACE;
                w.units  = UNITS_MARK;
                w.lastsel = LAST_NO;
            end
            STEP_SYM: begin
                w.emit    = 1'b1;
                w.tone    = 1'b1;
                w.units   = UNITS_MARK;
                w.lastsel = LAST_NO;
                w.cond    = COND_NEXT;
                w.next    = STEP_GAP;
                w.alt     = STEP_GAP;
            end
            STEP_GAP: begin
                w.emit    = 1'b1;
                w.tone    = 1'b0;
                w.units   = UNITS_GAP;
                w.lastsel = LAST_SYM;
                w.inc_sym = 1'b1;
                w.cond    = COND_LAST;
                w.next    = STEP_SYM;
                w.alt     = STEP_FETCH;
            end
            STEP_SPACE: begin
                w.emit    = 1'b1;
                w.tone    = 1'b0;
                w.units   = UNITS_FOUR;
                w.lastsel = LAST_YES;
                w.cond    = COND_NEXT;
                w.next    = STEP_FETCH;
                w.alt     = STEP_FETCH;
            end
            default: w = '0;
        endcase
        return w;
    endfunction

    // letter table: symbol count in bits 7..4, symbol i in bit i (1 = dash)
    function automatic logic [7:0] letter_code(input logic [4:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = 8'h22; // a
            5'd1:    c = 8'h41; // b
            5'd2:    c = 8'h45; // c
            5'd3:    c = 8'h31; // d
            5'd4:    c = 8'h10; // e
            5'd5:    c = 8'h44; // f
            5'd6:    c = 8'h33; // g
            5'd7:    c = 8'h40; // h
            5'd8:    c = 8'h20; // i
            5'd9:    c = 8'h4E; // j
            5'd10:   c = 8'h35; // k
            5'd11:   c = 8'h42; // l
            5'd12:   c = 8'h23; // m
            5'd13:   c = 8'h21; // n
            5'd14:   c = 8'h37; // o
            5'd15:   c = 8'h46; // p
            5'd16:   c = 8'h4B; // q
            5'd17:   c = 8'h32; // r
            5'd18:   c = 8'h30; // s
            5'd19:   c = 8'h11; // t
            5'd20:   c = 8'h34; // u
            5'd21:   c = 8'h48; // v
            5'd22:   c = 8'h36; // w
            5'd23:   c = 8'h49; // x
            5'd24:   c = 8'h4D; // y
            5'd25:   c = 8'h43; // z
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- sv/morse_code_keyer.sv -----
// top level: morse keyer built from a microcoded sequencer and its datapath
`timescale 1ns / 1ps

// Morse keyer. Each input beat carries one ASCII byte; letters (either case)
// come out as a run of segments: a tone segment per dot (1 unit) or dash
// (3 units), each followed by 1 unit of silence, or 3 units after the final
// symbol, which carries tlast. A space gives one 4-unit silent segment with
// tlast; every other byte is consumed and gives nothing. Durations are
// units times the unit length register (reset 100). The user must write
// it on the cfg channel only while the keyer is idle; the block does not
// enforce this. The microprogram spends one step per segment through a
// single output register, and a segment step waits while the output is
// stalled. Input is taken only in the fetch step, so one character is in
// flight at a time.
module morse_code_keyer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,    // unit_length
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // char_code
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // duration [17:0], zero [23:18]
    output logic        m_axis_tuser,  // tone_on
    output logic        m_axis_tlast   // last
);

    mck_pkg::t_ctl              ctl;
    mck_pkg::t_status           status;
    logic [mck_pkg::DurW-1:0]   duration;

    // microcode sequencer
    mck_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_ctl      (ctl)
    );

    // datapath
    mck_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_char      (s_axis_tdata),
        .i_ctl       (ctl),
        .o_status    (status),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_tone      (m_axis_tuser),
        .o_duration  (duration),
        .o_last      (m_axis_tlast)
    );

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = {6'd0, duration};

endmodule

// ----- sv/mck_sequencer.sv -----
// microcode sequencer: step counter, control store lookup and branch logic
`timescale 1ns / 1ps

module mck_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  mck_pkg::t_status i_status,
    output mck_pkg::t_ctl    o_ctl
);

    mck_pkg::t_step  r_step;
    mck_pkg::t_step  n_step;
    mck_pkg::t_uword w;
    logic            step_done;

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= mck_pkg::STEP_FETCH;
        end else begin
            r_step <= n_step;
        end
    end

    // decode the current control word and pick the next step
    always_comb begin
        w         = mck_pkg::ucode(r_step);
        step_done = !w.emit || i_status.out_free;
        n_step    = r_step;
        case (w.cond)
            mck_pkg::COND_NEXT: begin
                if (step_done) n_step = w.next;
            end
            mck_pkg::COND_LAST: begin
                if (step_done) n_step = i_status.sym_last ? w.alt : w.next;
            end
            mck_pkg::COND_DECODE: begin
                if (i_in_valid && i_status.in_space) begin
                    n_step = w.alt;
                end else if (i_in_valid && i_status.in_letter) begin
                    n_step = w.next;
                end
            end
            default: n_step = mck_pkg::STEP_FETCH;
        endcase

        o_in_ready    = w.accept;
        o_ctl.load    = w.accept && i_in_valid && i_status.in_letter;
        o_ctl.emit    = w.emit && step_done;
        o_ctl.tone    = w.tone;
        o_ctl.units   = w.units;
        o_ctl.lastsel = w.lastsel;
        o_ctl.inc_sym = w.inc_sym && step_done;
    end

    // a space beat always goes to the space step
    a_space_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_status.in_space) |=> r_step == mck_pkg::STEP_SPACE)
        else $error("space byte did not dispatch to space step");

    // input only taken in the fetch step
    a_accept_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_step == mck_pkg::STEP_FETCH)
        else $error("input ready outside fetch step");

endmodule

// ----- sv/mck_datapath.sv -----
// datapath: byte decode, letter code and symbol registers, duration and output beat
`timescale 1ns / 1ps

module mck_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    input  logic [mck_pkg::UnitW-1:0] i_cfg_data,
    input  logic [mck_pkg::CharW-1:0] i_char,
    input  mck_pkg::t_ctl             i_ctl,
    output mck_pkg::t_status          o_status,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_tone,
    output logic [mck_pkg::DurW-1:0]  o_duration,
    output logic                      o_last
);

    logic [mck_pkg::UnitW-1:0] r_unit;
    logic [7:0]                r_code;
    logic [1:0]                r_sym;
    logic                      r_valid;
    logic                      r_tone;
    logic [mck_pkg::DurW-1:0]  r_dur;
    logic                      r_last;

    logic                      is_upper;
    logic                      is_lower;
    logic [mck_pkg::CharW-1:0] folded;
    logic [mck_pkg::CharW-1:0] offset;
    logic [2:0]                sym_cnt;
    logic                      sym_last;
    logic                      dash;
    logic [2:0]                units;
    logic [mck_pkg::DurW-1:0]  unit_x;
    logic [mck_pkg::DurW-1:0]  dur;
    logic                      last;

    // unit length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit <= mck_pkg::UnitReset;
        end else if (i_cfg_valid) begin
            r_unit <= i_cfg_data;
        end
    end

    // classify the incoming byte and fold case
    always_comb begin
        is_upper = (i_char >= mck_pkg::ChUpperA) && (i_char <= mck_pkg::ChUpperZ);
        is_lower = (i_char >= mck_pkg::ChLowerA) && (i_char <= mck_pkg::ChLowerZ);
        folded   = is_upper ? i_char + mck_pkg::CaseShift : i_char;
        offset   = folded - mck_pkg::ChLowerA;
        o_status.in_space  = (i_char == mck_pkg::ChSpace);
        o_status.in_letter = is_upper || is_lower;
    end

    // letter code and symbol index
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_code <= mck_pkg::letter_code(offset[4:0]);
            r_sym  <= 2'd0;
        end else if (i_ctl.inc_sym) begin
            r_sym  <= r_sym + 2'd1;
        end
    end

    // current symbol, segment length and end flag
    always_comb begin
        sym_cnt  = r_code[6:4];
        sym_last = ({1'b0, r_sym} + 3'd1) == sym_cnt;
        dash     = r_code[{1'b0, r_sym}];
        case (i_ctl.units)
            mck_pkg::UNITS_MARK: units = dash ? 3'd3 : 3'd1;
            mck_pkg::UNITS_GAP:  units = sym_last ? 3'd3 : 3'd1;
            mck_pkg::UNITS_FOUR: units = 3'd4;
            default:             units = 3'd1;
        endcase
        unit_x = {2'b00, r_unit};
        case (units)
            3'd3:    dur = (unit_x << 1) + unit_x;
            3'd4:    dur = unit_x << 2;
            default: dur = unit_x;
        endcase
        case (i_ctl.lastsel)
            mck_pkg::LAST_YES: last = 1'b1;
            mck_pkg::LAST_SYM: last = sym_last;
            default:           last = 1'b0;
        endcase
        o_status.sym_last = sym_last;
        o_status.out_free = !r_valid || i_ready;
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.emit) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_tone <= i_ctl.tone;
            r_dur  <= dur;
            r_last <= last;
        end
    end

    assign o_valid    = r_valid;
    assign o_tone     = r_tone;
    assign o_duration = r_dur;
    assign o_last     = r_last;

    // a tone segment never ends a character
    a_tone_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_tone) |-> !r_last)
        else $error("tone segment flagged as last");

    // a new beat is only loaded when the output register is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.emit |-> (!r_valid || i_ready))
        else $error("output beat overwritten while stalled");

    // symbol steps stay within the letter's symbol count
    a_sym_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.emit && i_ctl.units == mck_pkg::UNITS_GAP) |-> ({1'b0, r_sym} < sym_cnt))
        else $error("symbol index beyond letter length");

endmodule

// ----- sim/tb.sv -----
// testbench: random and directed stimulus for the morse keyer, checked against a local predictor
`timescale 1ns / 1ps

module tb;

    localparam int LongHold    = 300;     // receiver stall that backs up the input
    localparam int DrainCycles = 16;
    localparam int CycleLimit  = 400000;
    localparam int ReportMax   = 10;

    // one keyed segment as seen on the output stream
    typedef struct packed {
        logic                     tone;
        logic [mck_pkg::DurW-1:0] ticks;
        logic                     eoc;
    } t_seg;

    // one character waiting to be sent, with its lead-in gap
    typedef struct packed {
        logic [mck_pkg::CharW-1:0] code;
        logic [3:0]                gap;
    } t_char_item;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    morse_code_keyer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    t_char_item chars_pending[$];
    t_seg       segments_due[$];
    logic [mck_pkg::UnitW-1:0] unit_len;
    int         chars_pushed;
    int         chars_offered;
    int         chars_taken;
    int         bad_segments;
    int         tx_idle_max;
    int         rx_idle_max;
    int         rx_wait;
    int         rx_hold;
    logic       stall_req;
    int unsigned cycle_count;

    // clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // dots and dashes of each letter, a first
    function automatic string morse_pattern(input int idx);
        case (idx)
            0: return ".-";    1: return "-...";  2: return "-.-.";  3: return "-..";
            4: return ".";     5: return "..-.";  6: return "--.";   7: return "....";
            8: return "..";    9: return ".---";  10: return "-.-";  11: return ".-..";
            12: return "--";   13: return "-.";   14: return "---";  15: return ".--.";
            16: return "--.-"; 17: return ".-.";  18: return "...";  19: return "-";
            20: return "..-";  21: return "...-"; 22: return ".--";  23: return "-..-";
            24: return "-.--"; 25: return "--..";
            default: return "";
        endcase
    endfunction

    function automatic void push_segment(input logic tone, input int units, input logic eoc);
        t_seg        s;
        logic [31:0] prod;
        prod    = units * {16'd0, unit_len};
        s.tone  = tone;
        s.ticks = prod[mck_pkg::DurW-1:0];
        s.eoc   = eoc;
        segments_due.push_back(s);
    endfunction

    // expected segments for one accepted character
    function automatic void predict_segments(input logic [mck_pkg::CharW-1:0] code);
        logic [mck_pkg::CharW-1:0] c;
        string pat;
        int n;
        int i;
        c = code;
        if (c == mck_pkg::ChSpace) begin
            push_segment(1'b0, 4, 1'b1);
            return;
        end
        if (c >= mck_pkg::ChUpperA && c <= mck_pkg::ChUpperZ) c = c + mck_pkg::CaseShift;
        if (c < mck_pkg::ChLowerA || c > mck_pkg::ChLowerZ) return;
        pat = morse_pattern(int'(c - mck_pkg::ChLowerA));
        n = pat.len();
        for (i = 0; i < n; i++) begin
            push_segment(1'b1, (pat[i] == "-") ? 3 : 1, 1'b0);
            if (i + 1 < n) push_segment(1'b0, 1, 1'b0);
            else push_segment(1'b0, 3, 1'b1);
        end
    endfunction

    // character beats: predict on acceptance
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            predict_segments(s_axis_tdata);
            chars_taken++;
        end
    end

    // character driver: one beat per pending item after its gap
    logic       tx_loaded;
    t_char_item tx_item;
    int         tx_wait;
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || chars_taken == chars_offered)) begin
            if (!tx_loaded && chars_pending.size() > 0) begin
                tx_item   = chars_pending.pop_front();
                tx_wait   = int'(tx_item.gap);
                tx_loaded = 1'b1;
            end
            if (tx_loaded && tx_wait == 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= tx_item.code;
                chars_offered++;
                tx_loaded = 1'b0;
            end else begin
                if (tx_loaded) tx_wait--;
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // segment monitor: compare each beat with the oldest expected segment
    always @(posedge i_clk) begin
        t_seg want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            rx_wait = int'($urandom_range(0, rx_idle_max));
            if (segments_due.size() == 0) begin
                bad_segments++;
                if (bad_segments <= ReportMax)
                    $display("unexpected segment: tone %0b data %h last %0b",
                             m_axis_tuser, m_axis_tdata, m_axis_tlast);
            end else begin
                want = segments_due.pop_front();
                if (m_axis_tuser !== want.tone || m_axis_tdata !== {6'b0, want.ticks}
                        || m_axis_tlast !== want.eoc) begin
                    bad_segments++;
                    if (bad_segments <= ReportMax)
                        $display({"segment mismatch: expected tone %0b dur %0d last %0b,",
                                  " got tone %0b data %h last %0b"},
                                 want.tone, want.ticks, want.eoc,
                                 m_axis_tuser, m_axis_tdata, m_axis_tlast);
                end
            end
        end
    end

    // receiver backpressure: short random waits, or one long hold on request
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (stall_req) begin
                rx_hold   = LongHold;
                stall_req = 1'b0;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic queue_char(input logic [mck_pkg::CharW-1:0] c);
        t_char_item it;
        it.code = c;
        it.gap  = 4'($urandom_range(0, tx_idle_max));
        chars_pending.push_back(it);
        chars_pushed++;
    endtask

    // mostly words of letters and spaces, some arbitrary bytes
    task automatic queue_text(input int count);
        int k;
        int r;
        logic [mck_pkg::CharW-1:0] c;
        for (k = 0; k < count; k++) begin
            r = int'($urandom_range(0, 99));
            if (r < 62) begin
                c = mck_pkg::ChLowerA + 8'($urandom_range(0, 25));
                if ($urandom_range(0, 1)) c = c - mck_pkg::CaseShift;
            end else if (r < 82) begin
                c = mck_pkg::ChSpace;
            end else begin
                c = 8'($urandom_range(0, 255));
            end
            queue_char(c);
        end
    endtask

    // wait until every character is taken and every segment seen
    task automatic wait_idle();
        while (chars_taken < chars_pushed || segments_due.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_unit(input logic [mck_pkg::UnitW-1:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        unit_len = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_idle(input int tx_max, input int rx_max);
        tx_idle_max = tx_max;
        rx_idle_max = rx_max;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        unit_len      = mck_pkg::UnitReset;
        chars_pushed  = 0;
        chars_offered = 0;
        chars_taken   = 0;
        bad_segments  = 0;
        rx_wait       = 0;
        rx_hold       = 0;
        stall_req     = 1'b0;
        tx_loaded     = 1'b0;
        tx_wait       = 0;
        cycle_count   = 0;
        set_idle(8, 8);
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, boundaries around the letter ranges, spaces
        queue_char(8'h00);
        queue_char(8'hFF);
        queue_char(mck_pkg::ChSpace);
        queue_char("A");
        queue_char("Z");
        queue_char("a");
        queue_char("z");
        queue_char(8'h40);
        queue_char(8'h5B);
        queue_char(8'h60);
        queue_char(8'h7B);
        queue_char("0");
        queue_char(8'h80);
        queue_char("e");
        queue_char("T");
        queue_char("j");
        queue_char("Q");
        queue_char("y");
        queue_char("h");
        queue_char("o");
        queue_char(mck_pkg::ChSpace);
        queue_char("M");
        wait_idle();

        // unit length of one, no idling on either side
        write_unit(16'd1);
        set_idle(0, 0);
        queue_text(48);
        wait_idle();

        // longest unit, full idling
        write_unit(16'hFFFF);
        set_idle(8, 8);
        queue_text(48);
        wait_idle();

        // zero unit length, receiver holds off while the sender keeps going
        write_unit(16'd0);
        set_idle(0, 8);
        stall_req = 1'b1;
        queue_text(48);
        wait_idle();

        // random unit lengths
        write_unit(16'($urandom_range(1, 65535)));
        set_idle(8, 0);
        queue_text(48);
        wait_idle();

        write_unit(16'($urandom_range(2, 16)));
        set_idle(4, 8);
        queue_text(48);
        wait_idle();

        if (bad_segments == 0 && segments_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- morse_code_keyer.f -----
sv/mck_pkg.sv
sv/mck_sequencer.sv
sv/mck_datapath.sv
sv/morse_code_keyer.sv
sim/tb.sv
